[src/brl_pkg.sv]
// Shared constants for the bounded random draw block.
// No dependencies.
package brl_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ValueW = 31;

  localparam logic [WordW-1:0] LCG_MUL       = 32'h5d58_8b65;
  localparam logic [WordW-1:0] FULL_SCALE    = 32'hffff_ffff;
  localparam logic [ValueW-1:0] ONE_RANGE    = 31'd1000;
  localparam logic [WordW-1:0] ONE_SPLIT     = 32'd500;
  localparam logic [ValueW-1:0] HUNDRED_RANGE = 31'd1009;
  localparam logic [WordW-1:0] HUNDRED_DIV   = 32'd10;
  localparam logic [ValueW-1:0] VALUE_MAX    = 31'h7fff_ffff;

endpackage

[src/bounded_random_rejection_lcg_top.sv]
// Top level of the bounded random draw: sequencer around the serial LCG and divider.
// Depends on brl_pkg, brl_lcg, brl_div.
//
//  channel | dir | word                      | accepted when
//  s_*     | in  | tdata[31:0] max_value     | s_tvalid & s_tready
//  m_*     | out | tdata[30:0] value, [31]=0 | m_tvalid & m_tready
//
// One word at a time; s_tready is high only while the sequencer is idle.
// Bound zero goes straight to the output register. Otherwise a scale divide, then
// per trial a serial LCG step and a serial divide, plus a divide by ten for bound 100,
// and the word is then handed to the output register.
// rst is synchronous, clears the seed to zero and m_tvalid, and returns the sequencer to idle.
// A result waiting in the output register does not block the next input word.
module bounded_random_rejection_lcg_top import brl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] max_value (signed)
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [30:0] value, [31] zero
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIVD, S_STEP, S_DIVR, S_DIV10, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    M_PLAIN, M_ONE, M_HUNDRED
  } mode_t;

  state_t            state;
  mode_t             mode;
  logic [ValueW-1:0] bound;
  logic [WordW-1:0]  d;
  logic [ValueW-1:0] v;
  logic              lcg_start;
  logic              lcg_done;
  logic [WordW-1:0]  seed;
  logic              div_start;
  logic              div_done;
  logic [WordW-1:0]  div_a;
  logic [WordW-1:0]  div_b;
  logic [WordW-1:0]  quo;
  logic              reject;

  logic [WordW-1:0]  neg;
  logic [ValueW-1:0] mag;

  assign neg = ~s_tdata + 32'd1;

  always_comb begin
    if (!s_tdata[31]) begin
      mag = s_tdata[ValueW-1:0];
    end else if (s_tdata == 32'h8000_0000) begin
      mag = VALUE_MAX;
    end else begin
      mag = neg[ValueW-1:0];
    end
  end

  assign s_tready = (state == S_IDLE);
  assign reject   = (quo > {1'b0, bound});

  brl_lcg u_lcg (
    .clk   (clk),
    .rst   (rst),
    .start (lcg_start),
    .done  (lcg_done),
    .seed  (seed)
  );

  brl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      lcg_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          lcg_start <= 1'b0;
          div_start <= s_tvalid && (mag != '0);
          if (s_tvalid) begin
            if (mag == '0) begin
              v     <= '0;
              state <= S_OUT;
            end else begin
              if (mag == 31'd1) begin
                mode  <= M_ONE;
                bound <= ONE_RANGE;
                div_b <= {1'b0, ONE_RANGE} + 32'd1;
              end else if (mag == 31'd100) begin
                mode  <= M_HUNDRED;
                bound <= HUNDRED_RANGE;
                div_b <= {1'b0, HUNDRED_RANGE} + 32'd1;
              end else begin
                mode  <= M_PLAIN;
                bound <= mag;
                div_b <= {1'b0, mag} + 32'd1;
              end
              div_a <= FULL_SCALE;
              state <= S_DIVD;
            end
          end
        end
        S_DIVD: begin
          lcg_start <= div_done;
          div_start <= 1'b0;
          if (div_done) begin
            d     <= (quo == '0) ? 32'd1 : quo;
            state <= S_STEP;
          end
        end
        S_STEP: begin
          lcg_start <= 1'b0;
          div_start <= lcg_done;
          if (lcg_done) begin
            div_a <= seed;
            div_b <= d;
            state <= S_DIVR;
          end
        end
        S_DIVR: begin
          lcg_start <= div_done && reject;
          div_start <= div_done && !reject && (mode == M_HUNDRED);
          if (div_done) begin
            if (reject) begin
              state <= S_STEP;
            end else begin
              case (mode)
                M_ONE: begin
                  v     <= {{(ValueW-1){1'b0}}, (quo > ONE_SPLIT)};
                  state <= S_OUT;
                end
                M_HUNDRED: begin
                  div_a <= quo;
                  div_b <= HUNDRED_DIV;
                  state <= S_DIV10;
                end
                default: begin
                  v     <= quo[ValueW-1:0];
                  state <= S_OUT;
                end
              endcase
            end
          end
        end
        S_DIV10: begin
          lcg_start <= 1'b0;
          div_start <= 1'b0;
          if (div_done) begin
            v     <= quo[ValueW-1:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          lcg_start <= 1'b0;
          div_start <= 1'b0;
          if (!m_tvalid || m_tready) begin
            m_tdata <= {1'b0, v};
            state   <= S_IDLE;
          end
        end
        default: begin
          lcg_start <= 1'b0;
          div_start <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/brl_lcg.sv]
// Seed register and bit-serial LCG step: seed <= seed * LCG_MUL + 1, one multiplier bit a cycle.
// Depends on brl_pkg.
module brl_lcg import brl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             done,
  output logic [WordW-1:0] seed
);

  logic [WordW-1:0] acc;
  logic [WordW-1:0] mcand;
  logic [WordW-1:0] mplier;
  logic [4:0]       cnt;
  logic             busy;
  logic [WordW-1:0] acc_next;

  assign acc_next = mplier[0] ? acc + mcand : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      seed <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy   <= 1'b1;
      cnt    <= '0;
      acc    <= {{(WordW-1){1'b0}}, 1'b1};
      mcand  <= LCG_MUL;
      mplier <= seed;
      done   <= 1'b0;
    end else if (busy) begin
      acc    <= acc_next;
      mcand  <= {mcand[WordW-2:0], 1'b0};
      mplier <= {1'b0, mplier[WordW-1:1]};
      cnt    <= cnt + 5'd1;
      done   <= (cnt == 5'd31);
      if (cnt == 5'd31) begin
        busy <= 1'b0;
        seed <= acc_next;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

[src/brl_div.sv]
// Restoring radix-2 divider, one quotient bit a cycle.
// Depends on brl_pkg.
module brl_div import brl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WordW-1:0] dividend,
  input  logic [WordW-1:0] divisor,
  output logic             done,
  output logic [WordW-1:0] quotient
);

  logic [WordW-1:0] rem;
  logic [WordW-1:0] dvs;
  logic [4:0]       cnt;
  logic             busy;
  logic [WordW:0]   trial;
  logic [WordW:0]   diff;

  assign trial = {rem, quotient[WordW-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= '0;
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
      done     <= 1'b0;
    end else if (busy) begin
      if (!diff[WordW]) begin
        rem <= diff[WordW-1:0];
      end else begin
        rem <= trial[WordW-1:0];
      end
      quotient <= {quotient[WordW-2:0], ~diff[WordW]};
      cnt      <= cnt + 5'd1;
      done     <= (cnt == 5'd31);
      if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

[src/brl_checker.sv]
// Port-level checks for bounded_random_rejection_lcg_top, attached by bind.
// Depends on the top level's ports only.
module brl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[31])
    else $error("output pad bit set");

  // one word in flight: input closes after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice in a row");

  // a new result leaves the sequencer idle
  a_idle_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result presented while sequencer busy");

endmodule

bind bounded_random_rejection_lcg_top brl_checker u_brl_checker (.*);
